// ===== sv/u2u8_pkg.sv =====
package u2u8_pkg;

	localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
	localparam logic [15:0] HIGH_SUR_FIRST = 16'hd800;
	localparam logic [15:0] HIGH_SUR_LAST  = 16'hdbff;
	localparam logic [15:0] LOW_SUR_FIRST  = 16'hdc00;
	localparam logic [15:0] LOW_SUR_LAST   = 16'hdfff;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [7:0]  LEAD4          = 8'hf0;
	localparam logic [7:0]  LEAD3          = 8'he0;
	localparam logic [7:0]  LEAD2          = 8'hc0;
	localparam logic [7:0]  CONT           = 8'h80;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic            string_end;
	} bundle_t;

endpackage

// ===== sv/u2u8_front.sv =====
module u2u8_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [15:0]            code_unit,
	input  logic                   last_unit,
	input  logic [15:0]            capacity,
	output logic                   load,
	output u2u8_pkg::bundle_t      bundle,
	output logic [COUNT_BITS-1:0]  base_count
);
	import u2u8_pkg::*;

	localparam int WW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	logic                  pend_q;
	logic [9:0]            pend_bits_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  halted_q;

	logic [WW-1:0] cap_w;
	logic [WW-1:0] max_w;
	logic [WW-1:0] cap_eff;
	logic [WW-1:0] cnt_w;
	logic          fits1, fits2, fits3, fits4;
	logic          is_high, is_low;
	logic [20:0]   cp;
	logic [2:0]    nb;
	logic          pend_d;
	logic          halted_d;

	always_comb begin
		cap_w   = WW'(capacity);
		max_w   = WW'({COUNT_BITS{1'b1}});
		cap_eff = (cap_w > max_w) ? max_w : cap_w;
		cnt_w   = WW'(count_q);
		fits1   = (cnt_w + WW'(1)) <= cap_eff;
		fits2   = (cnt_w + WW'(2)) <= cap_eff;
		fits3   = (cnt_w + WW'(3)) <= cap_eff;
		fits4   = (cnt_w + WW'(4)) <= cap_eff;
		is_high = code_unit inside {[HIGH_SUR_FIRST:HIGH_SUR_LAST]};
		is_low  = code_unit inside {[LOW_SUR_FIRST:LOW_SUR_LAST]};
		cp      = SUPP_BASE + {1'b0, pend_bits_q, code_unit[9:0]};
	end

	always_comb begin
		nb              = 3'd0;
		bundle.bytes    = '0;
		pend_d          = 1'b0;
		halted_d        = halted_q;
		if (!halted_q) begin
			if (pend_q && is_low && fits4) begin
				nb = 3'd4;
				bundle.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
				bundle.bytes[1] = CONT | {2'd0, cp[17:12]};
				bundle.bytes[2] = CONT | {2'd0, cp[11:6]};
				bundle.bytes[3] = CONT | {2'd0, cp[5:0]};
			end else if (is_high) begin
				pend_d = !last_unit;
			end else if (code_unit < ONE_BYTE_LIMIT) begin
				if (fits1) begin
					nb = 3'd1;
					bundle.bytes[0] = code_unit[7:0];
				end else begin
					halted_d = 1'b1;
				end
			end else if (code_unit < TWO_BYTE_LIMIT) begin
				if (fits2) begin
					nb = 3'd2;
					bundle.bytes[0] = LEAD2 | {3'd0, code_unit[10:6]};
					bundle.bytes[1] = CONT | {2'd0, code_unit[5:0]};
				end else begin
					halted_d = 1'b1;
				end
			end else begin
				if (fits3) begin
					nb = 3'd3;
					bundle.bytes[0] = LEAD3 | {4'd0, code_unit[15:12]};
					bundle.bytes[1] = CONT | {2'd0, code_unit[11:6]};
					bundle.bytes[2] = CONT | {2'd0, code_unit[5:0]};
				end else begin
					halted_d = 1'b1;
				end
			end
		end
		bundle.byte_valid = (nb != 3'd0);
		bundle.last_idx   = (nb == 3'd0) ? 2'd0 : 2'(nb - 3'd1);
		bundle.string_end = last_unit;
		load              = accept && ((nb != 3'd0) || last_unit);
		base_count        = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_bits_q <= '0;
			count_q     <= '0;
			halted_q    <= 1'b0;
		end else if (accept) begin
			if (last_unit) begin
				pend_q      <= 1'b0;
				pend_bits_q <= '0;
				count_q     <= '0;
				halted_q    <= 1'b0;
			end else begin
				pend_q   <= pend_d;
				halted_q <= halted_d;
				count_q  <= count_q + COUNT_BITS'(nb);
				if (pend_d) begin
					pend_bits_q <= code_unit[9:0];
				end
			end
		end
	end

endmodule

// ===== sv/u2u8_serializer.sv =====
module u2u8_serializer #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  u2u8_pkg::bundle_t     bundle,
	input  logic [COUNT_BITS-1:0] base_count,
	output logic                  ready,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  byte_valid,
	output logic                  run_last,
	output logic                  string_end,
	output logic [15:0]           total_bytes
);
	import u2u8_pkg::*;

	logic                  vld_q;
	bundle_t               bun_q;
	logic [COUNT_BITS-1:0] base_q;
	logic [1:0]            idx_q;
	logic                  take;
	logic                  at_final;
	logic [COUNT_BITS-1:0] total;

	always_comb begin
		take        = vld_q && !out_stall;
		at_final    = (idx_q == bun_q.last_idx);
		ready       = !vld_q || (take && at_final);
		total       = base_q + COUNT_BITS'(idx_q) + COUNT_BITS'(bun_q.byte_valid);
		out_valid   = vld_q;
		out_byte    = bun_q.byte_valid ? bun_q.bytes[idx_q] : 8'd0;
		byte_valid  = bun_q.byte_valid;
		run_last    = at_final;
		string_end  = at_final && bun_q.string_end;
		total_bytes = 16'(total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (at_final) begin
				vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bun_q  <= bundle;
			base_q <= base_count;
		end
	end

endmodule

// ===== sv/utf16_to_utf8_encoder_unit.sv =====
// UTF-16 to UTF-8 encoder. Each accepted code unit is encoded and registered
// into a buffer of up to four bytes, which leaves one byte per output
// transaction: one to four per unit (its UTF-8 length; one for an end
// marker), none for a byteless unit not ending a string. The next unit is
// accepted in the cycle its predecessor's last byte is taken. A high
// surrogate is held for the next unit; out_capacity limits the bytes of one
// string, and every string closes with a result carrying string_end and the
// total byte count. out_capacity may be written only while the block is idle.
module utf16_to_utf8_encoder_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] out_capacity,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_end,
	output logic [15:0] total_bytes
);
	import u2u8_pkg::*;

	logic [15:0]           capacity_q;
	logic                  ready;
	logic                  accept;
	logic                  load;
	bundle_t               bundle;
	logic [COUNT_BITS-1:0] base_count;

	assign cfg_ready = 1'b1;
	assign in_stall  = !ready;
	assign accept    = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hffff;
		end else if (cfg_valid) begin
			capacity_q <= out_capacity;
		end
	end

	u2u8_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.capacity   (capacity_q),
		.load       (load),
		.bundle     (bundle),
		.base_count (base_count)
	);

	u2u8_serializer #(.COUNT_BITS(COUNT_BITS)) u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.bundle      (bundle),
		.base_count  (base_count),
		.ready       (ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.string_end  (string_end),
		.total_bytes (total_bytes)
	);

endmodule

// ===== test/testbench.sv =====
module testbench;

	import u2u8_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] out_capacity;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        last_unit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        string_end;
	logic [15:0] total_bytes;

	typedef struct packed {
		logic [7:0]  data;
		logic        has_byte;
		logic        unit_end;
		logic        str_end;
		logic [15:0] count;
	} res_t;

	typedef struct packed {
		logic        set_cap;
		logic [15:0] cap;
		logic [15:0] unit;
		logic        fin;
		logic        typed;
		logic [2:0]  nb;
		logic [31:0] bytes;
		logic [15:0] tot;
	} row_t;

	// set_cap, cap, unit, fin, typed, nb, bytes (first byte on top), total at last result
	row_t plan [27] = '{
		'{1'b1, 16'hffff, 16'h0000, 1'b0, 1'b1, 3'd1, 32'h00000000, 16'd1},
		'{1'b0, 16'h0000, 16'h007f, 1'b0, 1'b1, 3'd1, 32'h7f000000, 16'd2},
		'{1'b0, 16'h0000, 16'h0080, 1'b0, 1'b1, 3'd2, 32'hc2800000, 16'd4},
		'{1'b0, 16'h0000, 16'h07ff, 1'b0, 1'b1, 3'd2, 32'hdfbf0000, 16'd6},
		'{1'b0, 16'h0000, 16'h0800, 1'b0, 1'b1, 3'd3, 32'he0a08000, 16'd9},
		'{1'b0, 16'h0000, 16'hffff, 1'b0, 1'b1, 3'd3, 32'hefbfbf00, 16'd12},
		'{1'b0, 16'h0000, 16'hd800, 1'b0, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hdc00, 1'b0, 1'b1, 3'd4, 32'hf0908080, 16'd16},
		'{1'b0, 16'h0000, 16'hdbff, 1'b0, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hdfff, 1'b0, 1'b1, 3'd4, 32'hf48fbfbf, 16'd20},
		'{1'b0, 16'h0000, 16'hdc00, 1'b0, 1'b1, 3'd3, 32'hedb08000, 16'd23},
		'{1'b0, 16'h0000, 16'hd834, 1'b0, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'h0041, 1'b0, 1'b1, 3'd1, 32'h41000000, 16'd24},
		'{1'b0, 16'h0000, 16'hda00, 1'b1, 1'b1, 3'd0, 32'h00000000, 16'd24},
		'{1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 3'd1, 32'h00000000, 16'd1},
		'{1'b1, 16'h0000, 16'h0041, 1'b0, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hd800, 1'b0, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'h0042, 1'b1, 1'b1, 3'd0, 32'h00000000, 16'd0},
		'{1'b1, 16'h0005, 16'h0800, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hd800, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hdc00, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'h0041, 1'b1, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b1, 16'h0004, 16'hdbff, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hdc00, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'h0041, 1'b1, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b1, 16'h0003, 16'hd800, 1'b0, 1'b0, 3'd0, 32'h00000000, 16'd0},
		'{1'b0, 16'h0000, 16'hdfff, 1'b1, 1'b0, 3'd0, 32'h00000000, 16'd0}
	};

	res_t        utf8_due[$];
	res_t        run_buf [4];
	int          run_n;
	res_t        head;
	int          errors;
	bit          calm;
	bit          hold_req;

	logic        hi_held;
	logic [9:0]  hi_bits;
	logic [15:0] byte_cnt;
	logic        halted_str;
	logic [15:0] cap_reg;

	utf16_to_utf8_encoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.out_capacity (out_capacity),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_unit    (code_unit),
		.last_unit    (last_unit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.string_end   (string_end),
		.total_bytes  (total_bytes)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("[utf16_to_utf8_encoder_unit] ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic bit room(input int need);
		return 32'(byte_cnt) + need <= 32'(cap_reg);
	endfunction

	task automatic emit(input logic [7:0] b);
		byte_cnt = byte_cnt + 16'd1;
		run_buf[run_n] = '{b, 1'b1, 1'b0, 1'b0, byte_cnt};
		run_n++;
	endtask

	task automatic encode_unit(input logic [15:0] cu, input logic fin);
		logic        done;
		logic [20:0] cp;
		run_n = 0;
		done  = 1'b0;
		if (!halted_str) begin
			if (hi_held) begin
				hi_held = 1'b0;
				if (cu >= LOW_SUR_FIRST && cu <= LOW_SUR_LAST && room(4)) begin
					cp = SUPP_BASE + {1'b0, hi_bits, cu[9:0]};
					emit(LEAD4 | cp[20:18]);
					emit(CONT | cp[17:12]);
					emit(CONT | cp[11:6]);
					emit(CONT | cp[5:0]);
					done = 1'b1;
				end
			end
			if (!done) begin
				if (cu >= HIGH_SUR_FIRST && cu <= HIGH_SUR_LAST) begin
					if (!fin) begin
						hi_held = 1'b1;
						hi_bits = cu[9:0];
					end
				end else if (cu < ONE_BYTE_LIMIT) begin
					if (room(1))
						emit(cu[7:0]);
					else
						halted_str = 1'b1;
				end else if (cu < TWO_BYTE_LIMIT) begin
					if (room(2)) begin
						emit(LEAD2 | cu[10:6]);
						emit(CONT | cu[5:0]);
					end else begin
						halted_str = 1'b1;
					end
				end else begin
					if (room(3)) begin
						emit(LEAD3 | cu[15:12]);
						emit(CONT | cu[11:6]);
						emit(CONT | cu[5:0]);
					end else begin
						halted_str = 1'b1;
					end
				end
			end
		end
		if (fin) begin
			if (run_n == 0) begin
				run_buf[0] = '{8'h00, 1'b0, 1'b0, 1'b0, byte_cnt};
				run_n = 1;
			end
			run_buf[run_n-1].str_end = 1'b1;
			hi_held    = 1'b0;
			hi_bits    = '0;
			byte_cnt   = '0;
			halted_str = 1'b0;
		end
		if (run_n > 0)
			run_buf[run_n-1].unit_end = 1'b1;
	endtask

	task automatic queue_run();
		for (int k = 0; k < run_n; k++)
			utf8_due.push_back(run_buf[k]);
	endtask

	task automatic send_unit(input logic [15:0] cu, input logic fin);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		code_unit <= cu;
		last_unit <= fin;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (utf8_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid    <= 1'b1;
		out_capacity <= v;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_unit(input logic [15:0] cu, input logic fin);
		encode_unit(cu, fin);
		queue_run();
		send_unit(cu, fin);
	endtask

	initial begin
		int hold_left;
		int gap_left;
		out_stall = 1'b0;
		hold_left = 0;
		gap_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				out_stall <= 1'b1;
			end else begin
				gap_left = pick_gap();
				out_stall <= (gap_left > 0);
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (utf8_due.size() == 0) begin
				report("transaction with nothing pending", {24'h0, out_byte}, 32'd0);
			end else begin
				head = utf8_due.pop_front();
				if (out_byte !== head.data)
					report("out_byte", 32'(out_byte), 32'(head.data));
				if (byte_valid !== head.has_byte)
					report("byte_valid", 32'(byte_valid), 32'(head.has_byte));
				if (run_last !== head.unit_end)
					report("run_last", 32'(run_last), 32'(head.unit_end));
				if (string_end !== head.str_end)
					report("string_end", 32'(string_end), 32'(head.str_end));
				if (total_bytes !== head.count)
					report("total_bytes", 32'(total_bytes), 32'(head.count));
			end
		end
	end

	initial begin
		logic [15:0] str_units[$];
		int          len;
		int          r;
		int          done_n;
		logic [15:0] cap_pick;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		out_capacity = '0;
		in_valid     = 1'b0;
		code_unit    = '0;
		last_unit    = 1'b0;
		errors       = 0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		hi_held      = 1'b0;
		hi_bits      = '0;
		byte_cnt     = '0;
		halted_str   = 1'b0;
		cap_reg      = 16'hffff;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].set_cap)
				set_capacity(plan[i].cap);
			encode_unit(plan[i].unit, plan[i].fin);
			if (plan[i].typed) begin
				run_n = plan[i].nb;
				for (int k = 0; k < plan[i].nb; k++)
					run_buf[k] = '{plan[i].bytes[31-8*k -: 8], 1'b1, k == plan[i].nb - 1,
						plan[i].fin && k == plan[i].nb - 1,
						16'(plan[i].tot - plan[i].nb + 1 + k)};
				if (plan[i].nb == 0 && plan[i].fin) begin
					run_buf[0] = '{8'h00, 1'b0, 1'b1, 1'b1, plan[i].tot};
					run_n = 1;
				end
			end
			queue_run();
			send_unit(plan[i].unit, plan[i].fin);
		end

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0, 7:    cap_pick = 16'hffff;
				1:       cap_pick = 16'h0000;
				2:       cap_pick = 16'($urandom_range(1, 12));
				3:       cap_pick = 16'd4;
				4:       cap_pick = 16'($urandom_range(20, 120));
				5:       cap_pick = 16'($urandom_range(0, 65535));
				default: cap_pick = 16'd3;
			endcase
			set_capacity(cap_pick);
			calm   = (phase == 3);
			done_n = 0;
			while (done_n < 35) begin
				len = $urandom_range(1, 10);
				str_units.delete();
				while (str_units.size() < len) begin
					r = $urandom_range(0, 99);
					if (r < 25)
						str_units.push_back(16'($urandom_range(0, 127)));
					else if (r < 40)
						str_units.push_back(16'($urandom_range(128, 2047)));
					else if (r < 55)
						str_units.push_back(16'($urandom_range(0, 1) ?
							$urandom_range(16'h0800, 16'hd7ff) :
							$urandom_range(16'he000, 16'hffff)));
					else if (r < 75) begin
						str_units.push_back(16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST)));
						str_units.push_back(16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST)));
					end else if (r < 82)
						str_units.push_back(16'($urandom_range(HIGH_SUR_FIRST, HIGH_SUR_LAST)));
					else if (r < 89)
						str_units.push_back(16'($urandom_range(LOW_SUR_FIRST, LOW_SUR_LAST)));
					else
						str_units.push_back(16'($urandom_range(0, 65535)));
				end
				foreach (str_units[k]) begin
					offer_unit(str_units[k], k == str_units.size() - 1);
					done_n++;
					// back-pressure the output long enough to fill the block
					if (phase == 0 && done_n == 15)
						hold_req = 1'b1;
					if (phase == 4 && done_n == 20)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("[utf16_to_utf8_encoder_unit] OK");
		else
			$display("[utf16_to_utf8_encoder_unit] ERROR");
		$finish;
	end

endmodule
